// ===== hw/rtl/wbct_pkg.sv =====
`default_nettype none
package wbct_pkg;
   localparam int DEF_LINE_BITS       = 4;
   localparam int DEF_FIRST_SET_BITS  = 12;
   localparam int DEF_SECOND_SET_BITS = 16;
   localparam int DEF_WAYS            = 4;
   localparam int DEF_ADDR_BITS       = 48;
   localparam int AGE_BITS            = 16;

   // outcome of one tag lookup in one level
   typedef struct packed {
      logic hit;
      logic ev_dirty;
   } wbct_lvl_res_type;
endpackage
`default_nettype wire

// ===== hw/rtl/two_level_writeback_cache_tags.sv =====
`default_nettype none
// channel   | ports                                   | handshake
// request   | req_op, req_address                     | start && !busy
// response  | rsp_l1_hit .. rsp_l2_writebacks         | rsp_valid, one cycle
// config    | psel penable pwrite paddr pwdata prdata | psel&&penable&&pwrite
//
// An L1 hit passes through S_L1 and back to idle, a miss also through S_FILL,
// and a miss with a dirty L1 victim also through S_WB; each state does one
// read-modify-write of a tag row, as each row memory has a single read port.
// After reset a clearing pass writes zero rows in both memories, with busy
// high. The response cannot be stalled.
module two_level_writeback_cache_tags #(
   parameter int LINE_BITS       = wbct_pkg::DEF_LINE_BITS,
   parameter int FIRST_SET_BITS  = wbct_pkg::DEF_FIRST_SET_BITS,
   parameter int SECOND_SET_BITS = wbct_pkg::DEF_SECOND_SET_BITS,
   parameter int WAYS            = wbct_pkg::DEF_WAYS,
   parameter int ADDR_BITS       = wbct_pkg::DEF_ADDR_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [47:0] req_address,
   output logic             rsp_valid,
   output logic             rsp_l1_hit,
   output logic             rsp_l1_writeback,
   output logic             rsp_l2_fill_hit,
   output logic             rsp_l2_writeback_hit,
   output logic [1:0]       rsp_l2_accesses,
   output logic [1:0]       rsp_l2_writebacks,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import wbct_pkg::*;

   localparam int TAG1 = ADDR_BITS - LINE_BITS - FIRST_SET_BITS;
   localparam int TAG2 = ADDR_BITS - LINE_BITS - SECOND_SET_BITS;
   localparam int PTRW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW1 = WAYS * (TAG1 + AGE_BITS + 2) + PTRW;
   localparam int ROW2 = WAYS * (TAG2 + AGE_BITS + 2) + PTRW;
   localparam int CLRB = (FIRST_SET_BITS > SECOND_SET_BITS) ? FIRST_SET_BITS
                                                             : SECOND_SET_BITS;
   localparam logic       ADDR_LRU = 1'b0;
   localparam logic [1:0] S_IDLE = 2'd0, S_L1 = 2'd1, S_FILL = 2'd2, S_WB = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic                 clr_ff, clr_in;
   logic [CLRB-1:0]      cnt_ff, cnt_in;
   logic                 lru_ff, lru_in;
   logic                 op_ff;
   logic [ADDR_BITS-1:0] addr_ff, va1_ff;
   logic                 ev1_ff, fhit_ff, same_ff;
   logic [1:0]           l2wb_ff;
   logic [ROW2-1:0]      fwd_ff;
   logic                 rv_ff, rhit_ff, rwb_ff, rfh_ff, rwh_ff;
   logic [1:0]           racc_ff, rl2wb_ff;

   logic [63:0]          in_ext;
   logic [ADDR_BITS-1:0] addr_in;
   logic                 accept;

   logic                 we1, we2;
   logic [FIRST_SET_BITS-1:0]  ra1, wa1;
   logic [SECOND_SET_BITS-1:0] ra2, wa2, fset, vset;
   logic [ROW1-1:0]      rd1, nrow1, wd1;
   logic [ROW2-1:0]      rd2, row2, nrow2, wd2;
   logic [TAG2-1:0]      tag2;
   logic [TAG1-1:0]      evt1;
   logic [TAG2-1:0]      evt2;
   wbct_lvl_res_type     res1, res2;
   logic [ADDR_BITS-1:0] va1;

   assign in_ext  = 64'(req_address);
   assign addr_in = in_ext[ADDR_BITS-1:0];
   assign busy    = clr_ff || (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign pready  = 1'b1;
   assign prdata  = (paddr == ADDR_LRU) ? {31'b0, lru_ff} : 32'b0;
   assign lru_in  = (psel && penable && pwrite && paddr == ADDR_LRU) ? pwdata[0] : lru_ff;

   assign fset = addr_ff[LINE_BITS +: SECOND_SET_BITS];
   assign vset = va1_ff[LINE_BITS +: SECOND_SET_BITS];
   assign va1  = {evt1, addr_ff[LINE_BITS +: FIRST_SET_BITS], {LINE_BITS{1'b0}}};

   // L1 row memory: read at accept, write back in S_L1
   assign ra1 = addr_in[LINE_BITS +: FIRST_SET_BITS];
   assign wa1 = clr_ff ? cnt_ff[FIRST_SET_BITS-1:0]
                       : addr_ff[LINE_BITS +: FIRST_SET_BITS];
   assign we1 = clr_ff ? ({1'b0, cnt_ff} < (CLRB+1)'(2**FIRST_SET_BITS))
                       : (state_ff == S_L1);
   assign wd1 = clr_ff ? '0 : nrow1;

   wbct_ram #(.WIDTH(ROW1), .DEPTH(2**FIRST_SET_BITS)) u_ram1 (
      .clock(clock), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1)
   );

   wbct_level #(.WAYS(WAYS), .TAG_BITS(TAG1)) u_lvl1 (
      .row_i(rd1), .tag_i(addr_ff[ADDR_BITS-1 -: TAG1]), .wr_i(op_ff),
      .lru_i(lru_ff), .row_o(nrow1), .res_o(res1), .ev_tag_o(evt1)
   );

   // L2 row memory: fill in S_FILL, victim write in S_WB; forward the fill
   // row when the victim lands in the same set
   assign ra2  = (state_ff == S_FILL) ? vset : fset;
   assign wa2  = clr_ff ? cnt_ff[SECOND_SET_BITS-1:0]
                        : ((state_ff == S_WB) ? vset : fset);
   assign we2  = clr_ff ? ({1'b0, cnt_ff} < (CLRB+1)'(2**SECOND_SET_BITS))
                        : (state_ff == S_FILL || state_ff == S_WB);
   assign wd2  = clr_ff ? '0 : nrow2;
   assign row2 = (state_ff == S_WB && same_ff) ? fwd_ff : rd2;
   assign tag2 = (state_ff == S_WB) ? va1_ff[ADDR_BITS-1 -: TAG2]
                                    : addr_ff[ADDR_BITS-1 -: TAG2];

   wbct_ram #(.WIDTH(ROW2), .DEPTH(2**SECOND_SET_BITS)) u_ram2 (
      .clock(clock), .we(we2), .waddr(wa2), .wdata(wd2), .raddr(ra2), .rdata(rd2)
   );

   wbct_level #(.WAYS(WAYS), .TAG_BITS(TAG2)) u_lvl2 (
      .row_i(row2), .tag_i(tag2), .wr_i(state_ff == S_WB),
      .lru_i(lru_ff), .row_o(nrow2), .res_o(res2), .ev_tag_o(evt2)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_L1;
         S_L1:    state_in = res1.hit ? S_IDLE : S_FILL;
         S_FILL:  state_in = ev1_ff ? S_WB : S_IDLE;
         S_WB:    state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      clr_in = clr_ff && (cnt_ff != '1);
      cnt_in = clr_ff ? cnt_ff + 1'b1 : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_ff   <= 1'b1;
         cnt_ff   <= '0;
         lru_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         lru_ff   <= lru_in;
         rv_ff    <= (state_ff == S_L1 && res1.hit) || (state_ff == S_FILL && !ev1_ff)
                     || (state_ff == S_WB);
      end
   end

   // payload: hold the item, victim address and partial results
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         addr_ff <= addr_in;
      end
      if (state_ff == S_L1) begin
         ev1_ff  <= res1.ev_dirty;
         va1_ff  <= va1;
         rhit_ff <= res1.hit;
         rwb_ff  <= 1'b0;
         rfh_ff  <= 1'b0;
         rwh_ff  <= 1'b0;
         racc_ff <= 2'd0;
         rl2wb_ff <= 2'd0;
      end
      if (state_ff == S_FILL) begin
         fhit_ff  <= res2.hit;
         l2wb_ff  <= {1'b0, res2.ev_dirty};
         fwd_ff   <= nrow2;
         same_ff  <= (vset == fset);
         rwb_ff   <= 1'b0;
         rfh_ff   <= res2.hit;
         rwh_ff   <= 1'b0;
         racc_ff  <= 2'd1;
         rl2wb_ff <= {1'b0, res2.ev_dirty};
      end
      if (state_ff == S_WB) begin
         rwb_ff   <= 1'b1;
         rfh_ff   <= fhit_ff;
         rwh_ff   <= res2.hit;
         racc_ff  <= 2'd2;
         rl2wb_ff <= l2wb_ff + {1'b0, res2.ev_dirty};
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_l1_hit           = rhit_ff;
   assign rsp_l1_writeback     = rwb_ff;
   assign rsp_l2_fill_hit      = rfh_ff;
   assign rsp_l2_writeback_hit = rwh_ff;
   assign rsp_l2_accesses      = racc_ff;
   assign rsp_l2_writebacks    = rl2wb_ff;

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_l1_hit && (rsp_l2_accesses != 2'd0)))
      else $error("L1 hit reported L2 traffic");
   a_wb_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_l1_writeback == (rsp_l2_accesses == 2'd2)))
      else $error("writeback flag and L2 access count disagree");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_L1)
      else $error("accepted item did not start lookup");
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> busy && !rsp_valid)
      else $error("activity during clearing pass");
endmodule
`default_nettype wire

// ===== hw/rtl/wbct_ram.sv =====
`default_nettype none
module wbct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/wbct_level.sv =====
`default_nettype none
module wbct_level #(
   parameter int WAYS     = 4,
   parameter int TAG_BITS = 32,
   parameter int PTRW     = (WAYS > 1) ? $clog2(WAYS) : 1,
   parameter int ROWW     = WAYS * (TAG_BITS + wbct_pkg::AGE_BITS + 2) + PTRW
) (
   input  wire logic [ROWW-1:0]         row_i,
   input  wire logic [TAG_BITS-1:0]     tag_i,
   input  wire logic                    wr_i,
   input  wire logic                    lru_i,
   output logic [ROWW-1:0]              row_o,
   output wbct_pkg::wbct_lvl_res_type   res_o,
   output logic [TAG_BITS-1:0]          ev_tag_o
);
   import wbct_pkg::*;

   localparam int ENT = TAG_BITS + AGE_BITS + 2;

   logic [WAYS-1:0]     vld, dty, match;
   logic [TAG_BITS-1:0] tg [WAYS];
   logic [AGE_BITS-1:0] age [WAYS];
   logic [AGE_BITS-1:0] na [WAYS];
   logic [PTRW-1:0]     hw, vw, ptr, nptr;
   logic                hit, full;
   logic [AGE_BITS-1:0] best;

   always_comb begin
      ptr = row_i[WAYS*ENT +: PTRW];
      for (int w = 0; w < WAYS; w++) begin
         tg[w]    = row_i[w*ENT +: TAG_BITS];
         age[w]   = row_i[w*ENT+TAG_BITS +: AGE_BITS];
         dty[w]   = row_i[w*ENT+TAG_BITS+AGE_BITS];
         vld[w]   = row_i[w*ENT+TAG_BITS+AGE_BITS+1];
         match[w] = vld[w] && (tg[w] == tag_i);
      end
      hit = |match;
      hw  = '0;
      for (int w = WAYS-1; w >= 0; w--) begin
         if (match[w]) hw = PTRW'(w);
      end
      // age every valid way except the hit way
      for (int w = 0; w < WAYS; w++) begin
         if (!vld[w]) na[w] = age[w];
         else if (hit && hw == PTRW'(w)) na[w] = '0;
         else if (age[w] != '1) na[w] = age[w] + 1'b1;
         else na[w] = age[w];
      end
      full = &vld;
      nptr = (ptr == PTRW'(WAYS-1)) ? '0 : ptr + 1'b1;
      vw   = '0;
      best = na[0];
      if (!full) begin
         for (int w = WAYS-1; w >= 0; w--) begin
            if (!vld[w]) vw = PTRW'(w);
         end
      end else if (lru_i) begin
         best = na[0];
         for (int w = 1; w < WAYS; w++) begin
            if (na[w] > best) begin
               best = na[w];
               vw   = PTRW'(w);
            end
         end
      end else begin
         vw = ptr;
      end
      row_o = row_i;
      for (int w = 0; w < WAYS; w++) begin
         row_o[w*ENT+TAG_BITS +: AGE_BITS] = na[w];
      end
      if (hit) begin
         row_o[hw*ENT+TAG_BITS+AGE_BITS] = dty[hw] | wr_i;
      end else begin
         row_o[vw*ENT +: ENT] = {1'b1, wr_i, {AGE_BITS{1'b0}}, tag_i};
         if (full && !lru_i) row_o[WAYS*ENT +: PTRW] = nptr;
      end
      res_o.hit      = hit;
      res_o.ev_dirty = !hit && full && dty[vw];
      ev_tag_o       = tg[vw];
   end
endmodule
`default_nettype wire
